/* sv/slf_pkg.sv */
// ----------------------------------------------------------------------------
// slf_pkg: shared types and constants for the sync/length frame receiver
// Holds the byte codes, parser phases, result kinds and the result record.
// ----------------------------------------------------------------------------
package slf_pkg;

    localparam logic [7:0]  SYNC_BYTE     = 8'h5A;  // 'Z'
    localparam logic [7:0]  START_BYTE    = 8'h58;  // 'X'
    localparam logic [15:0] MAX_LEN_RESET = 16'd1032;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SYNCED  = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_SYNC  = 2'd2,
        KIND_LONG  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic        last;
    } result_t;

    typedef struct packed {
        logic    push;
        result_t res;
    } result_push_t;

endpackage

/* sv/slf_parser.sv */
// ----------------------------------------------------------------------------
// slf_parser: frame parser state machine
// Consumes one registered byte per step and produces at most one result.
// ----------------------------------------------------------------------------
module slf_parser
    import slf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   rx_byte,
    input  logic         cfg_write,
    input  logic [15:0]  cfg_data,
    output result_push_t out
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [15:0] max_len_reg;
    logic [15:0] size;
    logic        fin;

    assign size = {length_high_reg, rx_byte};
    assign fin  = (remaining_reg <= 16'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            length_high_reg <= '0;
            remaining_reg   <= '0;
            max_len_reg     <= MAX_LEN_RESET;
        end
        else
        begin
            phase_reg       <= phase_next;
            length_high_reg <= length_high_next;
            remaining_reg   <= remaining_next;
            if (cfg_write)
            begin
                max_len_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        length_high_next = length_high_reg;
        remaining_next   = remaining_reg;
        out.push         = 1'b0;
        out.res.kind     = KIND_DATA;
        out.res.data_byte = '0;
        out.res.last     = 1'b0;
        if (step)
        begin
            unique case (phase_reg)
                PH_SYNCED:
                begin
                    if (rx_byte == START_BYTE)
                    begin
                        phase_next = PH_LEN_HI;
                    end
                    else if (rx_byte != SYNC_BYTE)
                    begin
                        // byte that breaks sync is consumed, not re-examined
                        phase_next   = PH_HUNT;
                        out.push     = 1'b1;
                        out.res.kind = KIND_SYNC;
                    end
                end
                PH_LEN_HI:
                begin
                    length_high_next = rx_byte;
                    phase_next       = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    if (size > max_len_reg)
                    begin
                        phase_next   = PH_HUNT;
                        out.push     = 1'b1;
                        out.res.kind = KIND_LONG;
                    end
                    else if (size == 16'd0)
                    begin
                        phase_next   = PH_HUNT;
                        out.push     = 1'b1;
                        out.res.kind = KIND_EMPTY;
                    end
                    else
                    begin
                        remaining_next = size;
                        phase_next     = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    out.push          = 1'b1;
                    out.res.kind      = KIND_DATA;
                    out.res.data_byte = rx_byte;
                    out.res.last      = fin;
                    if (fin)
                    begin
                        remaining_next = '0;
                        phase_next     = PH_HUNT;
                    end
                    else
                    begin
                        remaining_next = remaining_reg - 16'd1;
                    end
                end
                default:
                begin
                    phase_next = (rx_byte == SYNC_BYTE) ? PH_SYNCED : PH_HUNT;
                end
            endcase
        end
    end

    // non-data results carry zero payload and no last mark
    a_nondata_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out.push && out.res.kind != KIND_DATA |-> out.res.data_byte == 8'd0 && !out.res.last)
        else $error("non-data result carries payload");

    // payload phase is only entered with a nonzero count
    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> remaining_reg != 16'd0)
        else $error("payload phase with zero count");

    // every payload step yields a result
    a_payload_push: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_PAYLOAD |-> out.push)
        else $error("payload byte dropped");

    // last byte of a frame returns to hunting
    a_last_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        out.push && out.res.last |=> phase_reg == PH_HUNT)
        else $error("last byte did not end frame");

endmodule

/* sv/slf_out_reg.sv */
// ----------------------------------------------------------------------------
// slf_out_reg: result register with skid stage
// Holds results toward the output stream; absorbs one result while stalled.
// ----------------------------------------------------------------------------
module slf_out_reg
    import slf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  result_push_t in,
    output logic         in_ready,
    output logic         m_tvalid,
    input  logic         m_tready,
    output result_t      m_res
);

    logic    m_valid_reg;
    result_t m_res_reg;
    logic    skid_valid_reg;
    result_t skid_res_reg;

    assign in_ready = !skid_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_res    = m_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!m_valid_reg || m_tready)
        begin
            m_valid_reg    <= skid_valid_reg || in.push;
            skid_valid_reg <= 1'b0;
        end
        else if (in.push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!m_valid_reg || m_tready)
        begin
            m_res_reg <= skid_valid_reg ? skid_res_reg : in.res;
        end
        else if (in.push && !skid_valid_reg)
        begin
            skid_res_reg <= in.res;
        end
    end

    // skid only fills behind a held output
    a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid full with empty output");

    // a stalled output with a push must fill the skid
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && !m_tready && in.push |=> skid_valid_reg)
        else $error("result lost under stall");

endmodule

/* sv/sync_length_frame_receiver.sv */
// ----------------------------------------------------------------------------
// sync_length_frame_receiver: sync and length-prefixed frame receiver
// Hunts for 'Z'..'Z' 'X', reads a 16-bit length, then passes payload bytes.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | contents
//  --------+-----------+---------------------+---------------------------------
//  s_*     | in        | s_tvalid/s_tready   | tdata[7:0] rx_byte
//  m_*     | out       | m_tvalid/m_tready   | tdata data_byte, tuser kind, tlast
//  cfg_*   | in        | cfg_valid/cfg_ready | cfg_data = max_frame_length
//
// One item per cycle sustained unless the skid is full; an accepted input item
// passes the input register, then the parser into the result register.
// Reset (rst_n low, async) returns to hunting and sets the maximum to 1032.
// A stalled output is absorbed by a one-deep skid stage; the input stalls
// only once the skid is full. cfg_ready is always high.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver
    import slf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_byte
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    // input register
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_ready;
    logic         step;
    result_push_t parse_out;
    result_t      m_res;

    // parser advances whenever a byte is held and the output side has room
    assign step      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || step;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    slf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out       (parse_out)
    );

    slf_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in       (parse_out),
        .in_ready (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = m_res.data_byte;
    assign m_tuser = m_res.kind;
    assign m_tlast = m_res.last;

endmodule
